### sv/approximate_shift_and_matcher_defines.svh
// Assertion macros for the approximate shift-and matcher.
`ifndef APPROXIMATE_SHIFT_AND_MATCHER_DEFINES_SVH
`define APPROXIMATE_SHIFT_AND_MATCHER_DEFINES_SVH

`define ASM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("approximate_shift_and_matcher: same-cycle check failed");

`define ASM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("approximate_shift_and_matcher: next-cycle check failed");

`endif

### sv/asm_pkg.sv
// Shared constants, codes and types of the approximate shift-and matcher.
package asm_pkg;

  localparam int MAX_PATTERN   = 64;
  localparam int MAX_ERRORS    = 8;
  localparam int ALPHABET_SIZE = 256;

  localparam int ACT_W      = 2;
  localparam int SYM_W      = 8;
  localparam int IDX_W      = 6;
  localparam int LEN_W      = 7;
  localparam int ERR_W      = 4;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int ADDR_W     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  typedef logic [MAX_PATTERN-1:0] mask_t;
  typedef logic [MAX_ERRORS:0][MAX_PATTERN-1:0] rows_t;
  typedef logic [ACT_W-1:0] action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_LOAD  = 2'd1;
  localparam action_t ACT_START = 2'd2;
  localparam action_t ACT_TEXT  = 2'd3;

  localparam cfg_idx_t CFG_LENGTH = 3'd0;
  localparam cfg_idx_t CFG_ERRORS = 3'd1;
  localparam cfg_idx_t CFG_INS    = 3'd2;
  localparam cfg_idx_t CFG_DEL    = 3'd3;
  localparam cfg_idx_t CFG_SUB    = 3'd4;

  typedef struct packed {
    logic              clr;
    logic              we;
    logic [ADDR_W-1:0] addr;
    mask_t             data;
  } mask_wr_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic sub;
  } term_en_t;

endpackage

### sv/asm_mask_store.sv
// Symbol mask memory with per-entry valid bits and write-to-read forwarding.
module asm_mask_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en,
  input  logic [asm_pkg::SYM_W-1:0] rd_sym,
  input  asm_pkg::mask_wr_t       wr,
  output asm_pkg::mask_t          rd_mask
);

  logic [asm_pkg::MAX_PATTERN-1:0]   mem [asm_pkg::ALPHABET_SIZE];
  logic [asm_pkg::ALPHABET_SIZE-1:0] vld_r;
  asm_pkg::mask_t                    mem_q_r;
  asm_pkg::mask_t                    fwd_data_r;
  logic                              fwd_r;
  logic                              live_r;
  logic                              in_range;
  logic [asm_pkg::ADDR_W-1:0]        rd_addr;

  assign in_range = ({1'b0, rd_sym} < (asm_pkg::SYM_W + 1)'(asm_pkg::ALPHABET_SIZE));
  assign rd_addr  = rd_sym[asm_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      fwd_r  <= 1'b0;
      live_r <= 1'b0;
    end else begin
      if (wr.clr) begin
        vld_r <= '0;
      end else if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_r  <= in_range && wr.we && (wr.addr == rd_addr);
        live_r <= in_range && !wr.clr && vld_r[rd_addr];
      end
    end
  end

  assign rd_mask = fwd_r ? fwd_data_r : (live_r ? mem_q_r : '0);

endmodule

### sv/asm_row_update.sv
// Next-state logic of the error rows for a search start or a text byte.
module asm_row_update (
  input  asm_pkg::action_t              action,
  input  asm_pkg::mask_t                mask,
  input  asm_pkg::rows_t                rows,
  input  logic [asm_pkg::LEN_W-1:0]     m,
  input  logic [asm_pkg::ERR_W-1:0]     k,
  input  asm_pkg::term_en_t             en,
  output asm_pkg::rows_t                rows_nxt,
  output logic                          found
);

  asm_pkg::mask_t top;
  asm_pkg::mask_t prev;
  asm_pkg::mask_t fresh;
  asm_pkg::mask_t cur;
  asm_pkg::mask_t shifted;
  asm_pkg::rows_t init_rows;
  asm_pkg::rows_t text_rows;

  assign top = asm_pkg::MAX_PATTERN'(1) << (m - asm_pkg::LEN_W'(1));

  always_comb begin
    init_rows[0] = '0;
    for (int j = 1; j <= asm_pkg::MAX_ERRORS; j++) begin
      if ((asm_pkg::ERR_W + 1)'(j) <= {1'b0, k}) begin
        init_rows[j] = (asm_pkg::MAX_PATTERN'(1) << (m - asm_pkg::LEN_W'(j)))
                       | init_rows[j-1];
      end else begin
        init_rows[j] = '0;
      end
    end
  end

  always_comb begin
    prev         = rows[0];
    fresh        = ((prev >> 1) | top) & mask;
    text_rows[0] = fresh;
    cur          = '0;
    shifted      = '0;
    for (int j = 1; j <= asm_pkg::MAX_ERRORS; j++) begin
      if ((asm_pkg::ERR_W + 1)'(j) <= {1'b0, k}) begin
        cur          = rows[j];
        shifted      = (en.sub ? prev : '0) | (en.del ? fresh : '0);
        fresh        = ((cur >> 1) & mask) | (en.ins ? prev : '0) | (shifted >> 1);
        prev         = cur;
        text_rows[j] = fresh | top;
      end else begin
        text_rows[j] = rows[j];
      end
    end
  end

  always_comb begin
    case (action)
      asm_pkg::ACT_START: rows_nxt = init_rows;
      asm_pkg::ACT_TEXT:  rows_nxt = text_rows;
      default:            rows_nxt = rows;
    endcase
  end

  assign found = (action == asm_pkg::ACT_TEXT) && fresh[0];

endmodule

### sv/approximate_shift_and_matcher.sv
// Top level of the approximate shift-and matcher: input stage, row state and result register.
// Two register stages: the input stage, then the result register that holds each request's result.
// Throughput: one request per cycle while no result is stalled; the row loop and mask read set it.
// A stalled result holds both stages, so in_stall follows out_stall while a result waits.
// Reset is synchronous: control, rows, counter, all mask valid bits and error count clear; length is 1.
// No clearing pass is needed after reset; the block accepts requests on the next cycle.
`include "approximate_shift_and_matcher_defines.svh"

module approximate_shift_and_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [asm_pkg::ACT_W-1:0]     in_action,
  input  logic [asm_pkg::SYM_W-1:0]     in_symbol,
  input  logic [asm_pkg::IDX_W-1:0]     in_pattern_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_match_found,
  output logic [asm_pkg::CNT_W-1:0]     out_text_position,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [asm_pkg::LEN_W-1:0] len_r;
  logic [asm_pkg::ERR_W-1:0] err_r;
  asm_pkg::term_en_t         en_r;

  logic                      a_valid_r;
  asm_pkg::action_t          a_action_r;
  logic [asm_pkg::SYM_W-1:0] a_symbol_r;
  logic [asm_pkg::IDX_W-1:0] a_index_r;

  asm_pkg::rows_t            rows_r;
  asm_pkg::rows_t            rows_nxt;
  logic [asm_pkg::CNT_W-1:0] cnt_r;
  logic [asm_pkg::CNT_W-1:0] cnt_nxt;

  logic                      out_valid_r;
  logic                      out_match_r;
  logic [asm_pkg::CNT_W-1:0] out_pos_r;

  logic                      adv;
  logic                      step;
  logic [asm_pkg::LEN_W-1:0] m;
  logic [asm_pkg::LEN_W-1:0] m_minus1;
  logic [asm_pkg::ERR_W-1:0] k_len;
  logic [asm_pkg::ERR_W-1:0] k;
  logic                      idx_ok;
  logic                      sym_ok;
  logic                      found;
  asm_pkg::mask_t            cur_mask;
  asm_pkg::mask_wr_t         wr;

  assign adv       = !out_valid_r || !out_stall;
  assign step      = adv && a_valid_r;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (len_r == '0) begin
      m = asm_pkg::LEN_W'(1);
    end else if (len_r > asm_pkg::LEN_W'(asm_pkg::MAX_PATTERN)) begin
      m = asm_pkg::LEN_W'(asm_pkg::MAX_PATTERN);
    end else begin
      m = len_r;
    end
  end

  assign m_minus1 = m - asm_pkg::LEN_W'(1);

  always_comb begin
    if ({{(asm_pkg::LEN_W - asm_pkg::ERR_W){1'b0}}, err_r} > m_minus1) begin
      k_len = m_minus1[asm_pkg::ERR_W-1:0];
    end else begin
      k_len = err_r;
    end
    if ({1'b0, k_len} > (asm_pkg::ERR_W + 1)'(asm_pkg::MAX_ERRORS)) begin
      k = asm_pkg::ERR_W'(asm_pkg::MAX_ERRORS);
    end else begin
      k = k_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= asm_pkg::LEN_W'(1);
      err_r <= '0;
      en_r  <= '{ins: 1'b1, del: 1'b1, sub: 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asm_pkg::CFG_LENGTH: len_r  <= cfg_data[asm_pkg::LEN_W-1:0];
        asm_pkg::CFG_ERRORS: err_r  <= cfg_data[asm_pkg::ERR_W-1:0];
        asm_pkg::CFG_INS:    en_r.ins <= cfg_data[0];
        asm_pkg::CFG_DEL:    en_r.del <= cfg_data[0];
        asm_pkg::CFG_SUB:    en_r.sub <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_action_r <= in_action;
      a_symbol_r <= in_symbol;
      a_index_r  <= in_pattern_index;
    end
  end

  assign idx_ok = ({1'b0, a_index_r} <= m_minus1);
  assign sym_ok = ({1'b0, a_symbol_r} < (asm_pkg::SYM_W + 1)'(asm_pkg::ALPHABET_SIZE));

  always_comb begin
    wr.clr  = step && (a_action_r == asm_pkg::ACT_CLEAR);
    wr.we   = step && (a_action_r == asm_pkg::ACT_LOAD) && idx_ok && sym_ok;
    wr.addr = a_symbol_r[asm_pkg::ADDR_W-1:0];
    wr.data = cur_mask | (asm_pkg::MAX_PATTERN'(1) << (m_minus1 - {1'b0, a_index_r}));
  end

  asm_mask_store u_mask_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_sym  (in_symbol),
    .wr      (wr),
    .rd_mask (cur_mask)
  );

  asm_row_update u_row_update (
    .action   (a_action_r),
    .mask     (cur_mask),
    .rows     (rows_r),
    .m        (m),
    .k        (k),
    .en       (en_r),
    .rows_nxt (rows_nxt),
    .found    (found)
  );

  always_comb begin
    case (a_action_r)
      asm_pkg::ACT_START: cnt_nxt = '0;
      asm_pkg::ACT_TEXT:  cnt_nxt = cnt_r + asm_pkg::CNT_W'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      rows_r <= rows_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_match_r <= found;
      out_pos_r   <= cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_found   = out_match_r;
  assign out_text_position = out_pos_r;

  `ASM_ASSERT_SAME(a_hold_back, out_valid_r && out_stall, in_stall)
  `ASM_ASSERT_NEXT(a_quiet_non_text, step && (a_action_r != asm_pkg::ACT_TEXT), !out_match_found)
  `ASM_ASSERT_NEXT(a_start_zero, step && (a_action_r == asm_pkg::ACT_START), out_pos_r == '0)
  `ASM_ASSERT_NEXT(a_text_count, step && (a_action_r == asm_pkg::ACT_TEXT), cnt_r == $past(cnt_r) + asm_pkg::CNT_W'(1))

endmodule
